@@ design/brfd_pkg.sv @@
// Shared types, command codes and display tables for the relay and fan command decoder.
package brfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int RELAY_W = 3;
	localparam int SPEED_W = 3;
	localparam int LINES_W = 4;

	// ASCII command characters
	localparam logic [BYTE_W-1:0] CH_L   = 8'h4C;
	localparam logic [BYTE_W-1:0] CH_F   = 8'h46;
	localparam logic [BYTE_W-1:0] CH_U   = 8'h55;
	localparam logic [BYTE_W-1:0] CH_D   = 8'h44;
	localparam logic [BYTE_W-1:0] CH_ONE = 8'h31;
	localparam logic [BYTE_W-1:0] CH_TWO = 8'h32;
	localparam logic [BYTE_W-1:0] CH_THR = 8'h33;

	localparam logic [SPEED_W-1:0] SPEED_OFF = 3'd0;
	localparam logic [SPEED_W-1:0] SPEED_MIN = 3'd1;
	localparam logic [SPEED_W-1:0] SPEED_MAX = 3'd5;

	typedef struct packed {
		logic [RELAY_W-1:0] relay_states;
		logic               fan_enabled;
		logic [SPEED_W-1:0] speed_level;
		logic [LINES_W-1:0] speed_drive;
		logic [LINES_W-1:0] bar_leds;
	} result_t;

	function automatic logic [LINES_W-1:0] drive_lines(input logic [SPEED_W-1:0] spd);
		logic [LINES_W-1:0] d;
		case (spd)
			3'd1:    d = 4'b0100;
			3'd2:    d = 4'b0010;
			3'd3:    d = 4'b0001;
			3'd4:    d = 4'b0110;
			3'd5:    d = 4'b1000;
			default: d = 4'b0000;
		endcase
		return d;
	endfunction

	function automatic logic [LINES_W-1:0] bar_lines(input logic [SPEED_W-1:0] spd);
		logic [LINES_W-1:0] b;
		case (spd)
			3'd2:    b = 4'b1000;
			3'd3:    b = 4'b1100;
			3'd4:    b = 4'b1110;
			3'd5:    b = 4'b1111;
			default: b = 4'b0000;
		endcase
		return b;
	endfunction

endpackage

@@ design/brfd_core.sv @@
// Command pairing, decode and relay/fan state update.
module brfd_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_take,
	input  logic [brfd_pkg::BYTE_W-1:0]  item_byte,
	output logic                         has_result,
	output brfd_pkg::result_t            result
);

	logic                          phase_q;
	logic [brfd_pkg::BYTE_W-1:0]   first_q;
	logic [brfd_pkg::RELAY_W-1:0]  relay_q;
	logic                          fan_q;
	logic [brfd_pkg::SPEED_W-1:0]  speed_q;

	logic [brfd_pkg::RELAY_W-1:0]  relay_d;
	logic                          fan_d;
	logic [brfd_pkg::SPEED_W-1:0]  speed_d;

	assign has_result = item_valid && phase_q;

	always_comb begin
		relay_d = relay_q;
		fan_d   = fan_q;
		speed_d = speed_q;
		if (first_q == brfd_pkg::CH_L && item_byte == brfd_pkg::CH_ONE) begin
			relay_d = relay_q ^ 3'b001;
		end else if (first_q == brfd_pkg::CH_L && item_byte == brfd_pkg::CH_TWO) begin
			relay_d = relay_q ^ 3'b010;
		end else if (first_q == brfd_pkg::CH_L && item_byte == brfd_pkg::CH_THR) begin
			relay_d = relay_q ^ 3'b100;
		end else if (first_q == brfd_pkg::CH_F && item_byte == brfd_pkg::CH_ONE) begin
			fan_d   = !fan_q;
			speed_d = fan_q ? brfd_pkg::SPEED_OFF : brfd_pkg::SPEED_MIN;
		end else if (first_q == brfd_pkg::CH_U && item_byte == brfd_pkg::CH_ONE) begin
			if (speed_q >= brfd_pkg::SPEED_MIN && speed_q < brfd_pkg::SPEED_MAX) begin
				speed_d = speed_q + 3'd1;
			end
		end else if (first_q == brfd_pkg::CH_D && item_byte == brfd_pkg::CH_ONE) begin
			if (speed_q > brfd_pkg::SPEED_MIN && speed_q <= brfd_pkg::SPEED_MAX) begin
				speed_d = speed_q - 3'd1;
			end
		end
	end

	always_comb begin
		result.relay_states = relay_d;
		result.fan_enabled  = fan_d;
		result.speed_level  = speed_d;
		result.speed_drive  = brfd_pkg::drive_lines(speed_d);
		result.bar_leds     = brfd_pkg::bar_lines(speed_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			relay_q <= '0;
			fan_q   <= 1'b0;
			speed_q <= brfd_pkg::SPEED_OFF;
		end else if (item_take) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				relay_q <= relay_d;
				fan_q   <= fan_d;
				speed_q <= speed_d;
			end
		end
	end

	// hold the first character of a pair
	always_ff @(posedge clk) begin
		if (item_take && !phase_q) begin
			first_q <= item_byte;
		end
	end

endmodule

@@ design/brfd_obuf.sv @@
// Output register with skid stage for result requests.
module brfd_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  brfd_pkg::result_t  push_data,
	output logic               out_valid,
	input  logic               out_ready,
	output brfd_pkg::result_t  out_data
);

	logic               out_valid_q;
	logic               skid_valid_q;
	brfd_pkg::result_t  out_q;
	brfd_pkg::result_t  skid_q;
	logic               push;
	logic               drain;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && !skid_valid_q;
	assign drain      = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

@@ design/two_byte_relay_fan_command_decoder_unit.sv @@
// Top level of the two-byte relay and fan command decoder.
// Serial bytes enter on in_valid/in_ready and are paired into two-character
// commands (L1, L2, L3 toggle relays; F1 toggles the fan; U1/D1 step the speed).
// The second byte of each pair produces one result request showing relays, fan,
// speed, speed drive lines and bar LEDs; the first byte produces none. One byte
// is taken per cycle unless a completed pair's result finds the skid stage full:
// a byte is registered in stage one, decoded there, and the result lands in an
// output register backed by a one-entry skid stage, so the input keeps flowing
// while a result waits.
module two_byte_relay_fan_command_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [brfd_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [brfd_pkg::RELAY_W-1:0]  relay_states,
	output logic                          fan_enabled,
	output logic [brfd_pkg::SPEED_W-1:0]  speed_level,
	output logic [brfd_pkg::LINES_W-1:0]  speed_drive,
	output logic [brfd_pkg::LINES_W-1:0]  bar_leds
);

	logic                          valid_s1;
	logic [brfd_pkg::BYTE_W-1:0]   byte_s1;
	logic                          has_result;
	logic                          buf_ready;
	logic                          adv_s1;
	brfd_pkg::result_t             result;
	brfd_pkg::result_t             out_data;

	// advance stage one unless its result has nowhere to go
	assign adv_s1   = valid_s1 && (!has_result || buf_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	brfd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_take  (adv_s1),
		.item_byte  (byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	brfd_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (has_result),
		.push_ready (buf_ready),
		.push_data  (result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign relay_states = out_data.relay_states;
	assign fan_enabled  = out_data.fan_enabled;
	assign speed_level  = out_data.speed_level;
	assign speed_drive  = out_data.speed_drive;
	assign bar_leds     = out_data.bar_leds;

`ifndef SYNTHESIS
	a_fan_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fan_enabled == (speed_level != 3'd0)))
		else $error("fan state and speed disagree");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (speed_level <= brfd_pkg::SPEED_MAX))
		else $error("speed out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> valid_s1 && $stable(byte_s1))
		else $error("stage one lost its byte while stalled");

	a_bar_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bar_leds != 4'd0) |-> (speed_drive != 4'd0))
		else $error("bar lit with no speed drive");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the two-byte relay and fan command decoder: random and directed byte streams.
`timescale 1ns / 1ps

module tb;
	import brfd_pkg::*;

	localparam int PLAN_ITEMS = 1650;
	localparam int LIMIT_NS   = 4_000_000;
	localparam int MAX_SHOWN  = 10;

	typedef struct {
		logic [BYTE_W-1:0] data;
		bit                drain;
	} rx_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [BYTE_W-1:0]   rx_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [RELAY_W-1:0]  relay_states;
	logic                fan_enabled;
	logic [SPEED_W-1:0]  speed_level;
	logic [LINES_W-1:0]  speed_drive;
	logic [LINES_W-1:0]  bar_leds;

	// Decoder state as seen from the outside
	bit                  second_half = 1'b0;
	logic [BYTE_W-1:0]   held_char = '0;
	logic [RELAY_W-1:0]  relays = '0;
	logic                fan = 1'b0;
	logic [SPEED_W-1:0]  spd = SPEED_OFF;

	rx_item_t            rx_plan[$];
	result_t             status_due[$];
	rx_item_t            next_rx;
	result_t             seen;
	result_t             want;
	int                  plan_total = 0;
	int                  sent_count = 0;
	int                  got_count = 0;
	int                  faults = 0;
	int                  in_gap = 0;
	int                  hold_left = 0;

	two_byte_relay_fan_command_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.relay_states (relay_states),
		.fan_enabled  (fan_enabled),
		.speed_level  (speed_level),
		.speed_drive  (speed_drive),
		.bar_leds     (bar_leds)
	);

	always #1 clk = ~clk;

	// Mostly short idles, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("relays=%b fan=%b speed=%0d drive=%b bar=%b",
			r.relay_states, r.fan_enabled, r.speed_level, r.speed_drive, r.bar_leds);
	endfunction

	// Advance the decoder state by one accepted byte; a completed pair yields a status
	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		result_t st;
		if (!second_half) begin
			held_char = b;
			second_half = 1'b1;
		end else begin
			second_half = 1'b0;
			if (held_char == CH_L && b == CH_ONE)
				relays ^= 3'b001;
			else if (held_char == CH_L && b == CH_TWO)
				relays ^= 3'b010;
			else if (held_char == CH_L && b == CH_THR)
				relays ^= 3'b100;
			else if (held_char == CH_F && b == CH_ONE) begin
				fan = ~fan;
				spd = fan ? SPEED_MIN : SPEED_OFF;
			end else if (held_char == CH_U && b == CH_ONE) begin
				if (spd >= SPEED_MIN && spd < SPEED_MAX)
					spd = spd + 3'd1;
			end else if (held_char == CH_D && b == CH_ONE) begin
				if (spd > SPEED_MIN && spd <= SPEED_MAX)
					spd = spd - 3'd1;
			end
			st.relay_states = relays;
			st.fan_enabled  = fan;
			st.speed_level  = spd;
			case (spd)
				3'd1:    begin st.speed_drive = 4'b0100; st.bar_leds = 4'b0000; end
				3'd2:    begin st.speed_drive = 4'b0010; st.bar_leds = 4'b1000; end
				3'd3:    begin st.speed_drive = 4'b0001; st.bar_leds = 4'b1100; end
				3'd4:    begin st.speed_drive = 4'b0110; st.bar_leds = 4'b1110; end
				3'd5:    begin st.speed_drive = 4'b1000; st.bar_leds = 4'b1111; end
				default: begin st.speed_drive = 4'b0000; st.bar_leds = 4'b0000; end
			endcase
			status_due.push_back(st);
		end
	endtask

	task automatic add_byte(input logic [BYTE_W-1:0] data, input bit drain);
		rx_item_t it;
		it.data  = data;
		it.drain = drain;
		rx_plan.push_back(it);
	endtask

	task automatic add_pair(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
			input bit drain);
		add_byte(a, drain);
		add_byte(b, 1'b0);
	endtask

	// Pick one of the six commands, speed steps favored so the full range is reached
	task automatic add_command(input bit drain);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			add_pair(CH_L, CH_ONE, drain);
		else if (r < 20)
			add_pair(CH_L, CH_TWO, drain);
		else if (r < 30)
			add_pair(CH_L, CH_THR, drain);
		else if (r < 37)
			add_pair(CH_F, CH_ONE, drain);
		else if (r < 72)
			add_pair(CH_U, CH_ONE, drain);
		else
			add_pair(CH_D, CH_ONE, drain);
	endtask

	// Driver: present the next planned byte, hold it until accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				decode_byte(rx_byte);
				sent_count++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (rx_plan.size() == 0 ||
						(rx_plan[0].drain && status_due.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					next_rx = rx_plan.pop_front();
					rx_byte  <= next_rx.data;
					in_valid <= 1'b1;
					// every fourth stretch runs back to back
					if ((sent_count / 150) % 4 != 3 && $urandom_range(0, 9) < 3)
						in_gap = pick_gap();
				end
			end
		end
	end

	// Monitor: check each result request against the oldest predicted status
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_count++;
				seen.relay_states = relay_states;
				seen.fan_enabled  = fan_enabled;
				seen.speed_level  = speed_level;
				seen.speed_drive  = speed_drive;
				seen.bar_leds     = bar_leds;
				if (status_due.size() == 0) begin
					faults++;
					if (faults <= MAX_SHOWN)
						$display("%0t: result %0d arrived with none outstanding: %s",
							$realtime, got_count, show(seen));
				end else begin
					want = status_due.pop_front();
					if (seen.relay_states !== want.relay_states ||
							seen.fan_enabled !== want.fan_enabled ||
							seen.speed_level !== want.speed_level ||
							seen.speed_drive !== want.speed_drive ||
							seen.bar_leds !== want.bar_leds) begin
						faults++;
						if (faults <= MAX_SHOWN)
							$display("%0t: result %0d: wanted %s, got %s",
								$realtime, got_count, show(want), show(seen));
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ((got_count / 80) % 4 != 1 && $urandom_range(0, 9) == 0)
					hold_left = pick_gap();
			end
		end
	end

	initial begin
		int k;
		int r;
		// Directed: every command, saturation at both speed ends, zero and all-ones bytes
		add_pair(CH_L, CH_ONE, 1'b0);
		add_pair(CH_L, CH_TWO, 1'b0);
		add_pair(CH_L, CH_THR, 1'b0);
		add_pair(8'h00, 8'hFF, 1'b0);
		add_pair(CH_U, CH_ONE, 1'b0);
		add_pair(CH_F, CH_ONE, 1'b0);
		add_pair(CH_D, CH_ONE, 1'b0);
		repeat (5) add_pair(CH_U, CH_ONE, 1'b0);
		add_pair(CH_D, CH_ONE, 1'b0);

		k = 0;
		while (rx_plan.size() < PLAN_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				add_command(k % 200 == 0);
			else if (r < 80)
				add_pair(CH_L, rand_byte(), k % 200 == 0);
			else if (r < 85)
				add_pair(rand_byte(), CH_ONE, k % 200 == 0);
			else if (r < 93)
				add_pair(rand_byte(), rand_byte(), k % 200 == 0);
			else
				add_byte(rand_byte(), k % 200 == 0);  // slip the pairing by one
			k++;
		end
		plan_total = rx_plan.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_count != plan_total) @(posedge clk);
		while (status_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (faults == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

endmodule
